>>> design/hkvt_pkg.sv
// Package for the hash keyed value table: word types, sizes and codes.
package hkvt_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int VALUE_BITS  = 32;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int HASH_W      = 32;
	localparam int ENTRY_W     = HASH_W + VALUE_BITS;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  key_byte;
		logic        last_byte;
		logic [31:0] value_in;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [31:0] key_hash;
	} out_t;

endpackage

>>> design/hkvt_ram.sv
// Generic single write, single read RAM with registered read data.
module hkvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/hash_keyed_value_table.sv
// Hash keyed value table: key bytes are folded into a one-at-a-time hash, one word per
// byte; on the word marked last_byte the hash is finalized and the stored entry hashes
// are searched from index 0 upward through a single RAM read port, each entry read in
// S_READ and compared in S_CMP. A set (opcode 0) overwrites the value of the first entry
// with an equal hash or appends a new entry; it fails with status 2 once the table holds
// MAX_ENTRIES entries, even for a stored key. A get (opcode 1) returns the stored value
// with status 0, or status 1 and zero when absent. Entries match by hash alone, so keys
// that collide share one entry. Every last byte yields exactly one result word carrying
// the finalized hash; other bytes yield none. S_IDLE folds each byte that is not the last
// and stays ready for the next; a last byte goes on to S_FINAL, to S_READ and S_CMP for
// each entry compared (up to the match, or every entry on a miss), then to S_RESP. A set
// on a full table, or any key on an empty table, skips the search. The result sits in an
// output register, so the next key's bytes are taken while it waits; the next key's
// result step holds, with the input blocked, only while the previous result has not
// been taken. The table needs no clearing pass: the entry count bounds every search.
module hash_keyed_value_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hkvt_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output hkvt_pkg::out_t out_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FINAL,
		S_READ,
		S_CMP,
		S_RESP
	} state_t;

	state_t                           state_q;
	logic [hkvt_pkg::HASH_W-1:0]      acc_q;       // running hash of the current key
	logic [hkvt_pkg::HASH_W-1:0]      hash_q;      // key hash, finalized in S_FINAL
	logic                             op_q;
	logic [hkvt_pkg::VALUE_BITS-1:0]  val_q;
	logic [hkvt_pkg::IDX_W-1:0]       idx_q;       // search position
	logic [hkvt_pkg::CNT_W-1:0]       cnt_q;       // entries in use
	logic [1:0]                       res_status_q;
	logic [hkvt_pkg::VALUE_BITS-1:0]  res_val_q;
	logic                             out_valid_q;
	hkvt_pkg::out_t                   out_q;

	logic                             ram_we;
	logic [hkvt_pkg::IDX_W-1:0]       ram_waddr;
	logic [hkvt_pkg::ENTRY_W-1:0]     ram_wdata;
	logic [hkvt_pkg::ENTRY_W-1:0]     ram_rdata;
	logic [hkvt_pkg::HASH_W-1:0]      rd_hash;
	logic [hkvt_pkg::VALUE_BITS-1:0]  rd_val;
	logic                             in_fire;
	logic [hkvt_pkg::HASH_W-1:0]      mixed;
	logic                             hit;
	logic                             last_entry;
	logic                             cnt_full;
	logic                             cnt_empty;
	logic                             resp_load;   // result moves into the output register

	// one mixing step: add byte, add h<<10, xor h>>6
	function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		t = h + {24'd0, b};
		t = t + (t << 10);
		return t ^ (t >> 6);
	endfunction

	// final avalanche: add h<<3, xor h>>11, add h<<15
	function automatic logic [31:0] finalize(input logic [31:0] h);
		logic [31:0] t;
		t = h + (h << 3);
		t = t ^ (t >> 11);
		return t + (t << 15);
	endfunction

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign mixed      = mix_byte(acc_q, in_data.key_byte);
	assign rd_hash    = ram_rdata[hkvt_pkg::ENTRY_W-1 -: hkvt_pkg::HASH_W];
	assign rd_val     = ram_rdata[hkvt_pkg::VALUE_BITS-1:0];
	assign hit        = (rd_hash == hash_q);
	assign last_entry = (hkvt_pkg::CNT_W'(idx_q) + hkvt_pkg::CNT_W'(1)) == cnt_q;
	assign cnt_full   = (cnt_q == hkvt_pkg::CNT_W'(hkvt_pkg::MAX_ENTRIES));
	assign cnt_empty  = (cnt_q == '0);
	assign resp_load  = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// RAM writes: overwrite on a set hit, append on a set miss
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {hash_q, val_q};
		case (state_q)
			S_FINAL: begin
				// empty table: append at entry 0 (hash finalized on the fly)
				ram_wdata = {finalize(hash_q), val_q};
				ram_waddr = cnt_q[hkvt_pkg::IDX_W-1:0];
				ram_we    = (op_q == hkvt_pkg::OP_SET) && cnt_empty;
			end
			S_CMP: begin
				if (op_q == hkvt_pkg::OP_SET) begin
					if (hit) begin
						ram_we    = 1'b1;
						ram_waddr = idx_q;
					end else if (last_entry) begin
						ram_we    = 1'b1;
						ram_waddr = cnt_q[hkvt_pkg::IDX_W-1:0];
					end
				end
			end
			default: ram_we = 1'b0;
		endcase
	end

	hkvt_ram #(
		.WIDTH (hkvt_pkg::ENTRY_W),
		.DEPTH (hkvt_pkg::MAX_ENTRIES)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			acc_q        <= '0;
			hash_q       <= '0;
			op_q         <= hkvt_pkg::OP_SET;
			val_q        <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			res_status_q <= hkvt_pkg::ST_OK;
			res_val_q    <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			// output register: a new result replaces a taken one in the same cycle
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_data.last_byte) begin
							acc_q   <= '0;
							hash_q  <= mixed;
							op_q    <= in_data.opcode;
							val_q   <= hkvt_pkg::VALUE_BITS'(in_data.value_in);
							state_q <= S_FINAL;
						end else begin
							acc_q <= mixed;
						end
					end
				end
				S_FINAL: begin
					hash_q    <= finalize(hash_q);
					idx_q     <= '0;
					res_val_q <= '0;
					if (op_q == hkvt_pkg::OP_SET && cnt_full) begin
						res_status_q <= hkvt_pkg::ST_FULL;
						state_q      <= S_RESP;
					end else if (cnt_empty) begin
						if (op_q == hkvt_pkg::OP_SET) begin
							res_status_q <= hkvt_pkg::ST_OK;
							cnt_q        <= cnt_q + hkvt_pkg::CNT_W'(1);
						end else begin
							res_status_q <= hkvt_pkg::ST_NOT_FOUND;
						end
						state_q <= S_RESP;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						res_status_q <= hkvt_pkg::ST_OK;
						if (op_q == hkvt_pkg::OP_GET) begin
							res_val_q <= rd_val;
						end
						state_q <= S_RESP;
					end else if (last_entry) begin
						if (op_q == hkvt_pkg::OP_SET) begin
							res_status_q <= hkvt_pkg::ST_OK;
							cnt_q        <= cnt_q + hkvt_pkg::CNT_W'(1);
						end else begin
							res_status_q <= hkvt_pkg::ST_NOT_FOUND;
						end
						state_q <= S_RESP;
					end else begin
						idx_q   <= idx_q + hkvt_pkg::IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						out_q.status    <= res_status_q;
						out_q.value_out <= 32'(res_val_q);
						out_q.key_hash  <= hash_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hkvt_pkg::CNT_W'(hkvt_pkg::MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			(cnt_q == $past(cnt_q) + hkvt_pkg::CNT_W'(1)) && ($past(op_q) == hkvt_pkg::OP_SET))
		else $error("entry count changed other than by one append");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (hkvt_pkg::CNT_W'(idx_q) < cnt_q))
		else $error("search reads an unused entry");

	a_full_only_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && res_status_q == hkvt_pkg::ST_FULL) |->
			(op_q == hkvt_pkg::OP_SET && cnt_full))
		else $error("full status without a set on a full table");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_FINAL || state_q == S_CMP) && op_q == hkvt_pkg::OP_SET)
		else $error("entry write outside a set");

endmodule

>>> bench/hash_keyed_value_table_tb.sv
// Self-checking testbench for the hash keyed value table: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module hash_keyed_value_table_tb;

	// Scoreboard: mirrors the table contents and the running key hash, and queues the
	// result expected for every key.
	class hash_table_scoreboard;
		logic [31:0]                     running_hash;
		int unsigned                     stored_count;
		logic [31:0]                     stored_hash [hkvt_pkg::MAX_ENTRIES];
		logic [hkvt_pkg::VALUE_BITS-1:0] stored_value [hkvt_pkg::MAX_ENTRIES];
		hkvt_pkg::out_t                  pending_results [$];
		int unsigned                     mismatches;
		int unsigned                     results_checked;
		int unsigned                     words_seen;
		int unsigned                     keys_seen;
		int unsigned                     stores_done;
		int unsigned                     stores_refused;
		int unsigned                     lookups_hit;
		int unsigned                     lookups_missed;

		function new();
			running_hash    = '0;
			stored_count    = 0;
			mismatches      = 0;
			results_checked = 0;
			words_seen      = 0;
			keys_seen       = 0;
			stores_done     = 0;
			stores_refused  = 0;
			lookups_hit     = 0;
			lookups_missed  = 0;
		endfunction

		// One byte of the one-at-a-time mix.
		function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
			h = h + 32'(b);
			h = h + (h << 10);
			h = h ^ (h >> 6);
			return h;
		endfunction

		function logic [31:0] finish_hash(logic [31:0] h);
			h = h + (h << 3);
			h = h ^ (h >> 11);
			h = h + (h << 15);
			return h;
		endfunction

		task flag(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			mismatches++;
		endtask

		// Accepted input word: fold the byte; on the last byte work out the result.
		function void note_word(hkvt_pkg::in_t w);
			hkvt_pkg::out_t r;
			logic [31:0]    h;
			int             hit;
			words_seen++;
			running_hash = fold_byte(running_hash, w.key_byte);
			if (!w.last_byte)
				return;
			h            = finish_hash(running_hash);
			running_hash = '0;
			keys_seen++;
			hit = -1;
			for (int i = 0; i < int'(stored_count); i++) begin
				if (hit < 0 && stored_hash[i] == h)
					hit = i;
			end
			r.key_hash  = h;
			r.value_out = '0;
			if (w.opcode == hkvt_pkg::OP_SET) begin
				if (stored_count >= hkvt_pkg::MAX_ENTRIES) begin
					// full table refuses every store, known key or not
					r.status = hkvt_pkg::ST_FULL;
					stores_refused++;
				end else begin
					if (hit >= 0) begin
						stored_value[hit] = hkvt_pkg::VALUE_BITS'(w.value_in);
					end else begin
						stored_hash[stored_count]  = h;
						stored_value[stored_count] = hkvt_pkg::VALUE_BITS'(w.value_in);
						stored_count++;
					end
					r.status = hkvt_pkg::ST_OK;
					stores_done++;
				end
			end else begin
				if (hit >= 0) begin
					r.status    = hkvt_pkg::ST_OK;
					r.value_out = 32'(stored_value[hit]);
					lookups_hit++;
				end else begin
					r.status = hkvt_pkg::ST_NOT_FOUND;
					lookups_missed++;
				end
			end
			pending_results.push_back(r);
		endfunction

		// Accepted result word: compare with the oldest expectation.
		task check_word(hkvt_pkg::out_t got);
			hkvt_pkg::out_t want;
			results_checked++;
			if (pending_results.size() == 0) begin
				flag($sformatf("unexpected result status=%0d value=%h hash=%h",
					got.status, got.value_out, got.key_hash));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					flag($sformatf("result %0d status %0d, want %0d",
						results_checked, got.status, want.status));
				if (got.value_out !== want.value_out)
					flag($sformatf("result %0d value_out %h, want %h",
						results_checked, got.value_out, want.value_out));
				if (got.key_hash !== want.key_hash)
					flag($sformatf("result %0d key_hash %h, want %h",
						results_checked, got.key_hash, want.key_hash));
			end
		endtask

		task report_leftover();
			while (pending_results.size() != 0) begin
				flag($sformatf("result never came: key_hash %h",
					pending_results[0].key_hash));
				void'(pending_results.pop_front());
			end
		endtask
	endclass

	// A key of up to eight bytes; byte i sits in bytes[8*i +: 8].
	typedef struct packed {
		logic [3:0]  len;
		logic [63:0] bytes;
	} key_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	hkvt_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	hkvt_pkg::out_t out_data;

	hash_table_scoreboard sb;
	key_t                 known_keys [$];
	int unsigned          items_sent = 0;
	bit                   tx_calm    = 1'b0;
	bit                   hold_done  = 1'b0;

	hash_keyed_value_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Both handshakes are sampled at the rising edge; inputs only move on the falling edge,
	// so the values seen here are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_word(in_data);
			if (out_valid && out_ready)
				sb.check_word(out_data);
		end
	end

	// Offer one word and hold it until taken. Entered and left on a falling edge.
	// Random idle cycles go in front of the word unless the sender is in its calm stretch.
	task send_word(input hkvt_pkg::in_t w);
		while (!tx_calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Stream one key. Opcode and value only count on the last byte; the other bytes carry
	// noise there so a design that latches them early gets caught.
	task send_key(input key_t k, input logic op, input logic [31:0] val);
		hkvt_pkg::in_t w;
		for (int i = 0; i < int'(k.len); i++) begin
			w.last_byte = (i == int'(k.len) - 1);
			w.key_byte  = k.bytes[8*i +: 8];
			w.opcode    = w.last_byte ? op : logic'($urandom_range(1));
			w.value_in  = w.last_byte ? val : $urandom;
			send_word(w);
		end
	endtask

	function key_t make_key(int n, logic [63:0] b);
		key_t k;
		k.len   = 4'(n);
		k.bytes = b;
		return k;
	endfunction

	function key_t random_key();
		key_t k;
		k.len   = ($urandom_range(99) < 80) ? 4'($urandom_range(4, 1)) : 4'($urandom_range(8, 5));
		k.bytes = {$urandom, $urandom};
		return k;
	endfunction

	// Receiver: random back-pressure, a calm window with out_ready pinned high, and one
	// long hold-off while the sender keeps pushing, so the output register and then the
	// input side back up.
	initial begin
		int unsigned rx_cycle;
		int unsigned hold_left;
		rx_cycle  = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (!hold_done && sb.results_checked >= 60) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_cycle >= 2000 && rx_cycle < 3500) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 21);
			end
		end
	end

	// Main sequence.
	initial begin
		key_t        k;
		logic [31:0] val;
		int unsigned guard;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part.
		send_key(make_key(1, 64'h00), hkvt_pkg::OP_GET, 32'h0000_0000);  // lookup on empty table
		send_key(make_key(1, 64'hFF), hkvt_pkg::OP_SET, 32'hFFFF_FFFF);
		send_key(make_key(1, 64'h00), hkvt_pkg::OP_SET, 32'h0000_0000);  // all-zero key
		send_key(make_key(1, 64'hFF), hkvt_pkg::OP_GET, 32'hFFFF_FFFF);
		// A leading zero byte leaves the hash untouched, so {00,FF} collides with {FF}
		send_key(make_key(2, 64'hFF00), hkvt_pkg::OP_GET, 32'h0000_0000);
		send_key(make_key(2, 64'hFF00), hkvt_pkg::OP_SET, 32'h8000_0001);  // shared entry
		send_key(make_key(1, 64'hFF), hkvt_pkg::OP_GET, 32'h0000_0000);
		send_key(make_key(4, 64'h8001_5AA5), hkvt_pkg::OP_SET, 32'h5555_AAAA);
		send_key(make_key(4, 64'h8001_5AA5), hkvt_pkg::OP_GET, 32'hAAAA_5555);
		send_key(make_key(2, 64'h017F), hkvt_pkg::OP_GET, 32'h0000_0000);  // absent key
		send_key(make_key(6, 64'hFFFF_FFFF_FFFF), hkvt_pkg::OP_SET, 32'h7FFF_FFFE);
		known_keys.push_back(make_key(1, 64'hFF));
		known_keys.push_back(make_key(1, 64'h00));
		known_keys.push_back(make_key(4, 64'h8001_5AA5));
		known_keys.push_back(make_key(6, 64'hFFFF_FFFF_FFFF));

		// Random part: mostly keys already seen so lookups and overwrites hit, with a steady
		// trickle of new keys that fills the table partway through; after that every store
		// is refused, stored keys included.
		while (items_sent < 1100) begin
			tx_calm = (items_sent >= 400 && items_sent < 600);
			if ($urandom_range(99) < 30) begin
				k = random_key();
				known_keys.push_back(k);
			end else begin
				k = known_keys[$urandom_range(known_keys.size() - 1)];
				if (k.len < 8 && $urandom_range(99) < 10) begin
					// same hash through a zero prefix
					k.bytes = {k.bytes[55:0], 8'h00};
					k.len   = k.len + 4'd1;
				end
			end
			val = $urandom;
			send_key(k, logic'($urandom_range(1)), val);
		end
		in_valid <= 1'b0;

		// Drain: wait for outstanding results, then past the longest search.
		guard = 0;
		while (sb.pending_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (150) @(posedge clk);
		sb.report_leftover();

		$display("Covered %0d key bytes in %0d keys; table reached %0d of %0d entries.",
			sb.words_seen, sb.keys_seen, sb.stored_count, hkvt_pkg::MAX_ENTRIES);
		$display("Stores %0d done, %0d refused on full table; lookups %0d hit, %0d missed.",
			sb.stores_done, sb.stores_refused, sb.lookups_hit, sb.lookups_missed);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
